>>> rtl/core/crf_pkg.sv
// Package for the contiguous free range finder: widths, register codes and stage types.
`timescale 1ns / 1ps

package crf_pkg;

    localparam int unsigned ADDR_W     = 64;
    localparam int unsigned PAGES_W    = 52;
    localparam int unsigned PAGE_SHIFT = 12;
    localparam int unsigned IN_DATA_W  = 120;  // base and pages, padded to whole bytes
    localparam int unsigned CFG_IDX_W  = 2;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [PAGES_W-1:0] pages_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LOW   = 2'd0,
        REG_WINDOW_HIGH  = 2'd1,
        REG_ALIGN_BYTES  = 2'd2,
        REG_WANTED_PAGES = 2'd3
    } cfg_reg_t;

    localparam addr_t ALIGN_RESET_M1     = addr_t'(4095);
    localparam addr_t WANTED_BYTES_RESET = addr_t'(4096);

    // entry after the window clip
    typedef struct packed {
        addr_t lo;
        addr_t hi;
        logic  in_win;
        logic  last;
    } span_t;

    // entry with its aligned start candidate
    typedef struct packed {
        addr_t lo;
        addr_t hi;
        addr_t cand;
        logic  take;
        logic  cand_ok;
        logic  last;
    } cand_t;

endpackage

>>> rtl/core/contiguous_free_range_finder.sv
// Stages a, b, c and a result register; a request's result (if any) comes out on m_*.
// Throughput: one entry per cycle while m_tready does not stall; the run state update is a loop
// at the last stage (two compares, three subtracts, two compares against the wanted byte count).
// Entries that give no result still pass through all stages.
// Reset: aresetn is synchronous, active low; clears the pipeline, the run state and
// restores window 0/0, alignment 4096 and one wanted page.
`timescale 1ns / 1ps

module contiguous_free_range_finder (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_we,
    input  logic [crf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [crf_pkg::ADDR_W-1:0]        cfg_data,
    // frame entries
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [crf_pkg::IN_DATA_W-1:0]     s_tdata,  // frame_base[63:0], frame_pages[115:64]
    input  logic                              s_tuser,  // frame_is_free
    input  logic                              s_tlast,  // last_entry
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [crf_pkg::ADDR_W-1:0]        m_tdata,  // claim_base[63:0]
    output logic                              m_tuser   // found
);

    // ---------------------------------------------------------------- config
    crf_pkg::addr_t window_low_reg;
    crf_pkg::addr_t window_high_reg;
    crf_pkg::addr_t align_m1_reg;
    logic           align_zero_reg;
    crf_pkg::addr_t wanted_bytes_reg;
    logic           wanted_zero_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_low_reg   <= '0;
            window_high_reg  <= '0;
            align_m1_reg     <= crf_pkg::ALIGN_RESET_M1;
            align_zero_reg   <= 1'b0;
            wanted_bytes_reg <= crf_pkg::WANTED_BYTES_RESET;
            wanted_zero_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (crf_pkg::cfg_reg_t'(cfg_index))
                crf_pkg::REG_WINDOW_LOW:   window_low_reg  <= cfg_data;
                crf_pkg::REG_WINDOW_HIGH:  window_high_reg <= cfg_data;
                crf_pkg::REG_ALIGN_BYTES: begin
                    align_m1_reg   <= cfg_data - crf_pkg::addr_t'(1);
                    align_zero_reg <= (cfg_data == '0);
                end
                crf_pkg::REG_WANTED_PAGES: begin
                    wanted_bytes_reg <= {cfg_data[crf_pkg::PAGES_W-1:0],
                                         {crf_pkg::PAGE_SHIFT{1'b0}}};
                    wanted_zero_reg  <= (cfg_data[crf_pkg::PAGES_W-1:0] == '0);
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- handshake
    logic a_valid_reg, b_valid_reg, c_valid_reg, m_tvalid_reg;
    logic out_free, fire_c, c_free, fire_b, b_free, fire_a, a_free;
    logic emit;

    assign out_free = !m_tvalid_reg || m_tready;
    assign fire_c   = c_valid_reg && out_free;
    assign c_free   = !c_valid_reg || fire_c;
    assign fire_b   = b_valid_reg && c_free;
    assign b_free   = !b_valid_reg || fire_b;
    assign fire_a   = a_valid_reg && b_free;
    assign a_free   = !a_valid_reg || fire_a;
    assign s_tready = a_free;

    // ---------------------------------------------------------------- stage a: input
    crf_pkg::addr_t  a_base_reg;
    crf_pkg::pages_t a_pages_reg;
    logic            a_free_reg;
    logic            a_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_free) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && a_free) begin
            a_base_reg  <= s_tdata[crf_pkg::ADDR_W-1:0];
            a_pages_reg <= s_tdata[crf_pkg::ADDR_W +: crf_pkg::PAGES_W];
            a_free_reg  <= s_tuser;
            a_last_reg  <= s_tlast;
        end
    end

    // window clip
    crf_pkg::addr_t a_end;
    crf_pkg::span_t b_next;

    always_comb begin
        a_end         = a_base_reg + {a_pages_reg, {crf_pkg::PAGE_SHIFT{1'b0}}};
        b_next.lo     = (a_base_reg > window_low_reg) ? a_base_reg : window_low_reg;
        b_next.hi     = (a_end < window_high_reg) ? a_end : window_high_reg;
        b_next.in_win = a_free_reg && !(a_end <= window_low_reg
                                        || a_base_reg >= window_high_reg);
        b_next.last   = a_last_reg;
    end

    // ---------------------------------------------------------------- stage b: span
    crf_pkg::span_t b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_free) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire_a) begin
            b_reg <= b_next;
        end
    end

    // aligned start candidate; zero alignment leaves lo untouched
    crf_pkg::cand_t c_next;
    crf_pkg::addr_t b_round;

    always_comb begin
        b_round        = (b_reg.lo + align_m1_reg) & ~align_m1_reg;
        c_next.lo      = b_reg.lo;
        c_next.hi      = b_reg.hi;
        c_next.cand    = align_zero_reg ? b_reg.lo : b_round;
        c_next.take    = b_reg.in_win && (b_reg.hi > b_reg.lo);
        c_next.cand_ok = c_next.cand < b_reg.hi;
        c_next.last    = b_reg.last;
    end

    // ---------------------------------------------------------------- stage c: run state
    crf_pkg::cand_t c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_free) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire_b) begin
            c_reg <= c_next;
        end
    end

    crf_pkg::addr_t run_start_reg, run_start_next;
    crf_pkg::addr_t run_stop_reg, run_stop_next;
    logic           run_open_reg, run_open_next;
    logic           answered_reg, answered_next;

    logic           restart;
    logic           ext_hi;
    logic           new_fit;
    logic           ext_fit;
    logic           match;
    crf_pkg::addr_t claim;
    crf_pkg::addr_t d_new, d_hi, d_stop;

    always_comb begin
        restart = !run_open_reg || (c_reg.lo > run_stop_reg);
        ext_hi  = c_reg.hi > run_stop_reg;
        d_new   = c_reg.hi - c_reg.cand;
        d_hi    = c_reg.hi - run_start_reg;
        d_stop  = run_stop_reg - run_start_reg;
        new_fit = d_new >= wanted_bytes_reg;
        ext_fit = (ext_hi ? d_hi : d_stop) >= wanted_bytes_reg;
        claim   = restart ? c_reg.cand : run_start_reg;

        run_start_next = run_start_reg;
        run_stop_next  = run_stop_reg;
        run_open_next  = run_open_reg;
        answered_next  = answered_reg;
        match          = 1'b0;
        emit           = 1'b0;

        if (answered_reg) begin
            if (c_reg.last) begin
                answered_next = 1'b0;
            end
        end else begin
            if (c_reg.take) begin
                if (restart) begin
                    if (!c_reg.cand_ok) begin
                        run_open_next = 1'b0;
                    end else begin
                        run_start_next = c_reg.cand;
                        run_stop_next  = c_reg.hi;
                        run_open_next  = 1'b1;
                        match          = new_fit && !wanted_zero_reg;
                    end
                end else begin
                    if (ext_hi) begin
                        run_stop_next = c_reg.hi;
                    end
                    match = ext_fit && !wanted_zero_reg;
                end
            end
            emit = match || c_reg.last;
            if (match && !c_reg.last) begin
                answered_next = 1'b1;
            end
        end

        // end of search wipes the run
        if (c_reg.last) begin
            run_start_next = '0;
            run_stop_next  = '0;
            run_open_next  = 1'b0;
            answered_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_start_reg <= '0;
            run_stop_reg  <= '0;
            run_open_reg  <= 1'b0;
            answered_reg  <= 1'b0;
        end else if (fire_c) begin
            run_start_reg <= run_start_next;
            run_stop_reg  <= run_stop_next;
            run_open_reg  <= run_open_next;
            answered_reg  <= answered_next;
        end
    end

    // ---------------------------------------------------------------- result register
    crf_pkg::addr_t m_base_reg;
    logic           m_found_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (fire_c && emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire_c && emit) begin
            m_found_reg <= match;
            m_base_reg  <= match ? claim : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_base_reg;
    assign m_tuser  = m_found_reg;

`ifndef SYNTH
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid_reg)
        else $error("result valid right after reset");

    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_found_reg) |-> (m_base_reg == '0))
        else $error("not-found result carries a nonzero base");

    a_open_run_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        run_open_reg |-> (run_stop_reg > run_start_reg))
        else $error("open run has no bytes");

    a_answer_latched: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire_c && match && !c_reg.last) |=> answered_reg)
        else $error("found result did not close the search");

    a_answered_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire_c && answered_reg) |-> !emit)
        else $error("answered search produced another result");
`endif

endmodule

>>> verif/tb.sv
// Testbench for contiguous_free_range_finder: directed table plus random searches vs. a predictor.
`timescale 1ns / 1ps

module tb;
    import crf_pkg::*;

    localparam int LAT = 3;

    typedef struct packed {
        addr_t  base;
        pages_t pages;
        logic   is_free;
        logic   last;
    } frame_t;

    typedef struct packed {
        logic  found;
        addr_t base;
    } claim_t;

    // how a directed row gets its expected result
    typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_MISS, EXP_HIT} exp_kind_t;

    typedef struct {
        bit        is_cfg;
        cfg_reg_t  reg_idx;
        addr_t     value;
        frame_t    f;
        exp_kind_t ek;
        addr_t     hit_base;
    } row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata;  // frame_base[63:0], frame_pages[115:64]
    logic                 s_tuser;  // frame_is_free
    logic                 s_tlast;  // last_entry
    logic                 m_tvalid;
    logic                 m_tready;
    logic [ADDR_W-1:0]    m_tdata;  // claim_base[63:0]
    logic                 m_tuser;  // found

    contiguous_free_range_finder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor copy of the registers and the run state
    addr_t  win_lo  = '0;
    addr_t  win_hi  = '0;
    addr_t  align_q = addr_t'(4096);
    pages_t want_q  = pages_t'(1);
    addr_t  run_lo  = '0;
    addr_t  run_hi  = '0;
    bit     run_open = 1'b0;
    bit     srch_done = 1'b0;

    claim_t claims_due[$];
    row_t   stim_rows[$];
    int     err_count = 0;
    int     send_idle_pct = 15;
    int     recv_stall_pct = 49;

    function automatic addr_t rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void clear_run();
        run_lo = '0;
        run_hi = '0;
        run_open = 1'b0;
        srch_done = 1'b0;
    endfunction

    function automatic void predict_claim(input frame_t f, output bit emits, output claim_t c);
        addr_t span_end, lo, hi, cand;
        bit    live, hit;
        emits = 1'b0;
        c = '{found: 1'b0, base: '0};
        if (srch_done) begin
            // search already answered: swallow entries up to the last one
            if (f.last)
                clear_run();
            return;
        end
        live = 1'b0;
        span_end = f.base + (addr_t'(f.pages) << PAGE_SHIFT);
        if (f.is_free && span_end > win_lo && f.base < win_hi) begin
            lo = (f.base > win_lo) ? f.base : win_lo;
            hi = (span_end < win_hi) ? span_end : win_hi;
            if (hi > lo) begin
                live = 1'b1;
                if (!run_open || lo > run_hi) begin
                    cand = (align_q == '0) ? lo : (lo + (align_q - 1)) & ~(align_q - 1);
                    if (cand >= hi) begin
                        run_open = 1'b0;
                        live = 1'b0;
                    end else begin
                        run_lo = cand;
                        run_hi = hi;
                        run_open = 1'b1;
                    end
                end else if (hi > run_hi) begin
                    run_hi = hi;
                end
            end
        end
        hit = live && want_q != '0 &&
              (run_hi - run_lo) >= (addr_t'(want_q) << PAGE_SHIFT);
        if (hit) begin
            emits = 1'b1;
            c = '{found: 1'b1, base: run_lo};
            if (f.last)
                clear_run();
            else
                srch_done = 1'b1;
        end else if (f.last) begin
            emits = 1'b1;
            clear_run();
        end
    endfunction

    task automatic report_mismatch(input string what, input addr_t got, input addr_t want);
        $display("%0t mismatch %s: got %h, want %h", $time, what, got, want);
        err_count++;
    endtask

    // result side: check against the oldest pending claim, then pick the next ready
    always @(posedge aclk) begin
        claim_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (claims_due.size() == 0) begin
                report_mismatch("result with none pending", m_tdata, '0);
            end else begin
                want = claims_due.pop_front();
                if (m_tuser !== want.found)
                    report_mismatch("found", addr_t'(m_tuser), addr_t'(want.found));
                if (m_tdata !== want.base)
                    report_mismatch("claim_base", m_tdata, want.base);
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_entry(input frame_t f, input exp_kind_t ek, input addr_t hit_base);
        bit     emits;
        claim_t c;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'h0, f.pages, f.base};
        s_tuser  <= f.is_free;
        s_tlast  <= f.last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_claim(f, emits, c);
        case (ek)
            EXP_NONE: emits = 1'b0;
            EXP_MISS: begin
                emits = 1'b1;
                c = '{found: 1'b0, base: '0};
            end
            EXP_HIT: begin
                emits = 1'b1;
                c = '{found: 1'b1, base: hit_base};
            end
            default: ;
        endcase
        if (emits)
            claims_due.push_back(c);
    endtask

    // drain all pending claims plus the pipeline, leaving the block idle
    task automatic settle();
        s_tvalid <= 1'b0;
        while (claims_due.size() != 0)
            @(posedge aclk);
        repeat (LAT + 3) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input addr_t value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_WINDOW_LOW:   win_lo = value;
            REG_WINDOW_HIGH:  win_hi = value;
            REG_ALIGN_BYTES:  align_q = value;
            REG_WANTED_PAGES: want_q = value[PAGES_W-1:0];
            default: ;
        endcase
    endtask

    task automatic add_cfg(input cfg_reg_t idx, input addr_t value);
        row_t r;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.value = value;
        r.f = '0;
        r.ek = EXP_MODEL;
        r.hit_base = '0;
        stim_rows.push_back(r);
    endtask

    task automatic add_item(input addr_t base, input pages_t pages, input bit is_free,
                            input bit last, input exp_kind_t ek, input addr_t hit_base);
        row_t r;
        r.is_cfg = 1'b0;
        r.reg_idx = REG_WINDOW_LOW;
        r.value = '0;
        r.f = '{base: base, pages: pages, is_free: is_free, last: last};
        r.ek = ek;
        r.hit_base = hit_base;
        stim_rows.push_back(r);
    endtask

    task automatic pick_settings();
        addr_t  lo, hi, al;
        pages_t w;
        case ($urandom_range(9))
            0, 1, 2: begin
                lo = '0;
                hi = '1;
            end
            3, 4, 5, 6: begin
                lo = rand64();
                hi = lo + (addr_t'($urandom_range(1, 64)) << PAGE_SHIFT)
                   + addr_t'($urandom_range(0, 4095));
            end
            7: begin
                hi = '1;
                lo = hi - (addr_t'($urandom_range(1, 64)) << PAGE_SHIFT);
            end
            8: begin
                lo = rand64();
                hi = rand64();
            end
            default: begin
                lo = '1;
                hi = '0;
            end
        endcase
        case ($urandom_range(9))
            0: al = '0;
            1: al = addr_t'($urandom_range(2, 100000));  // usually not a power of two
            2: al = addr_t'(1) << 63;
            3: al = rand64();
            default: al = addr_t'(1) << $urandom_range(0, 16);
        endcase
        case ($urandom_range(15))
            0: w = '0;
            1: w = pages_t'(rand64());
            2: w = '1;
            default: w = pages_t'($urandom_range(1, 8));
        endcase
        write_reg(REG_WINDOW_LOW, lo);
        write_reg(REG_WINDOW_HIGH, hi);
        write_reg(REG_ALIGN_BYTES, al);
        write_reg(REG_WANTED_PAGES, addr_t'(w));
    endtask

    // searches: mostly ordered entries near the window start, some noise entries
    task automatic run_phase(input int n_items);
        int     sent, len;
        addr_t  cursor, gap;
        frame_t f;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 10);
            cursor = win_lo - (addr_t'($urandom_range(0, 4)) << PAGE_SHIFT)
                   + (addr_t'($urandom_range(0, 8)) << PAGE_SHIFT);
            if ($urandom_range(2) == 0)
                cursor += addr_t'($urandom_range(1, 4095));
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(9) == 0) begin
                    f.base = rand64();
                    f.pages = pages_t'(rand64());
                    f.is_free = 1'($urandom_range(1));
                end else begin
                    f.base = cursor;
                    f.pages = ($urandom_range(19) == 0) ? pages_t'(rand64())
                                                        : pages_t'($urandom_range(0, 5));
                    f.is_free = ($urandom_range(3) != 0);
                    case ($urandom_range(9))
                        0, 1: gap = addr_t'($urandom_range(1, 3)) << PAGE_SHIFT;
                        2: gap = addr_t'($urandom_range(1, 4095));
                        3: gap = -(addr_t'(1) << PAGE_SHIFT);
                        default: gap = '0;
                    endcase
                    cursor = f.base + (addr_t'(f.pages) << PAGE_SHIFT) + gap;
                end
                f.last = (i == len - 1);
                send_entry(f, EXP_MODEL, '0);
            end
            sent += len;
        end
    endtask

    initial begin
        row_t r;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        s_tlast   <= 1'b0;
        m_tready  <= 1'b0;

        // window is empty out of reset
        add_item(64'h1000, 4, 1, 1, EXP_MISS, '0);
        add_cfg(REG_WINDOW_HIGH, '1);
        add_item(64'h0, 1, 1, 0, EXP_HIT, 64'h0);
        add_item(64'h5000, 1, 1, 1, EXP_NONE, '0);          // answered search
        add_item(64'h1001, 1, 1, 1, EXP_MODEL, '0);
        add_item(64'h0, 10, 0, 1, EXP_MISS, '0);            // busy last entry
        add_cfg(REG_WANTED_PAGES, 64'd3);
        add_item(64'h10000, 1, 1, 0, EXP_NONE, '0);
        add_item(64'h11000, 1, 1, 0, EXP_NONE, '0);
        add_item(64'h12000, 1, 1, 1, EXP_HIT, 64'h10000);   // match on the last entry
        add_item(64'h20000, 2, 1, 0, EXP_MODEL, '0);
        add_item(64'h30000, 5, 0, 0, EXP_MODEL, '0);        // busy entry keeps the run
        add_item(64'h22000, 1, 1, 1, EXP_MODEL, '0);
        add_item(64'h40000, 2, 1, 0, EXP_MODEL, '0);
        add_item(64'h43000, 2, 1, 1, EXP_MODEL, '0);        // gap restarts the run
        add_cfg(REG_WANTED_PAGES, 64'd0);
        add_item(64'h1000, 100, 1, 1, EXP_MISS, '0);
        add_cfg(REG_WANTED_PAGES, 64'd1);
        add_cfg(REG_ALIGN_BYTES, 64'd3000);
        add_item(64'h1, 2, 1, 1, EXP_MODEL, '0);
        add_cfg(REG_ALIGN_BYTES, 64'd0);
        add_item(64'h123, 1, 1, 1, EXP_MODEL, '0);
        add_cfg(REG_ALIGN_BYTES, 64'h8000_0000_0000_0000);
        add_item(64'h1000, 1, 1, 1, EXP_MODEL, '0);         // aligned start past span
        add_cfg(REG_ALIGN_BYTES, 64'd4096);
        add_item(64'hFFFF_FFFF_FFFF_F001, 1, 1, 1, EXP_MODEL, '0);  // entry end wraps
        add_cfg(REG_WINDOW_LOW, 64'hFFFF_FFFF_FFFF_F001);
        add_item(64'hFFFF_FFFF_FFFF_EFFF, 1, 1, 1, EXP_MODEL, '0);  // aligned start wraps
        add_item('1, '1, 1, 1, EXP_MODEL, '0);
        add_cfg(REG_WINDOW_LOW, 64'h8000);
        add_cfg(REG_WINDOW_HIGH, 64'hA000);
        add_cfg(REG_WANTED_PAGES, 64'd2);
        add_item(64'h6000, 8, 1, 1, EXP_MODEL, '0);         // clipped on both sides
        add_item(64'h9000, 0, 1, 1, EXP_MODEL, '0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_rows[i]) begin
            r = stim_rows[i];
            if (r.is_cfg) begin
                settle();
                write_reg(r.reg_idx, r.value);
            end else begin
                send_entry(r.f, r.ek, r.hit_base);
            end
        end

        for (int p = 0; p < 6; p++) begin
            if (p < 2) begin
                send_idle_pct = 15;
                recv_stall_pct = 49;
            end else if (p < 4) begin
                send_idle_pct = 49;
                recv_stall_pct = 15;
            end else begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            settle();
            pick_settings();
            run_phase(150);
        end

        settle();
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
